FILE: hw/rtl/percent_decoder_macros.svh
// Assertion macros shared by the decoder modules.
// Each takes a label, clock, reset and the expression, or ante and cons.
`ifndef PERCENT_DECODER_MACROS_SVH
`define PERCENT_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define PCD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

`define PCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

`else

`define PCD_ASSERT(lbl, clk, rst, prop)

`define PCD_ASSERT_IMP(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/pcd_pkg.sv
package pcd_pkg;

   // Character codes used by the decoder.
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TWO     = 8'h32;
   localparam logic [7:0] CH_FIVE    = 8'h35;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam int         HEX_ALPHA_BASE = 10;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_HEX = 2'd1;
   localparam logic [1:0] STATUS_TRUNC   = 2'd2;

   // Command queue sizing.
   localparam int QDEPTH = 4;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Escape parser phases.
   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_PCT  = 5'b00010,
      PH_DIG1 = 5'b00100,
      PH_PCT2 = 5'b01000,
      PH_DROP = 5'b10000
   } phase_type;

   // One command from the parser to the output side. A triple command
   // stands for the literal "%25"; last then belongs to its final byte.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
      logic       triple;
   } cmd_type;

   // Digit value 0..15, or 16 when the byte is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = 5'(c - CH_ZERO);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         v = 5'(c - CH_LOWER_A) + 5'(HEX_ALPHA_BASE);
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         v = 5'(c - CH_UPPER_A) + 5'(HEX_ALPHA_BASE);
      end
      return v;
   endfunction

endpackage

FILE: hw/rtl/pcd_if.sv
// Raw character channel.
interface pcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded character channel.
interface pcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic [1:0] status;

   modport source (output valid, output out_byte, output out_last, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input status,
                   output ready);
endinterface

FILE: hw/rtl/pcd_front.sv
// Escape parser: takes one character per cycle while the command queue is
// not full, and pushes a command for every character that produces output.
module pcd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             plus_to_space,
   pcd_req_if.sink          req,
   input  logic             q_full,
   output logic             q_push,
   output pcd_pkg::cmd_type q_cmd
);

   pcd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]         nibble_ff, nibble_in;
   logic               fdb_ff, fdb_in;
   logic               accept;
   logic [4:0]         hv;
   logic               fail;
   logic [1:0]         fail_status;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign hv        = pcd_pkg::hex_value(req.in_byte);

   always_comb begin
      phase_in    = phase_ff;
      nibble_in   = nibble_ff;
      fdb_in      = fdb_ff;
      q_push      = 1'b0;
      q_cmd       = '{data: req.in_byte, last: req.in_last,
                      status: pcd_pkg::STATUS_OK, triple: 1'b0};
      fail        = 1'b0;
      fail_status = pcd_pkg::STATUS_BAD_HEX;
      if (accept) begin
         unique case (phase_ff)
            pcd_pkg::PH_IDLE: begin
               if (req.in_byte == pcd_pkg::CH_PERCENT) begin
                  if (req.in_last) begin
                     fail        = 1'b1;
                     fail_status = pcd_pkg::STATUS_TRUNC;
                  end else begin
                     phase_in = pcd_pkg::PH_PCT;
                  end
               end else begin
                  q_push = 1'b1;
                  if (plus_to_space && req.in_byte == pcd_pkg::CH_PLUS) begin
                     q_cmd.data = pcd_pkg::CH_SPACE;
                  end
               end
            end
            pcd_pkg::PH_PCT: begin
               if (req.in_last) begin
                  fail        = 1'b1;
                  fail_status = pcd_pkg::STATUS_TRUNC;
               end else if (req.in_byte == pcd_pkg::CH_PERCENT) begin
                  fdb_in    = 1'b1;
                  nibble_in = 4'd0;
                  phase_in  = pcd_pkg::PH_DIG1;
               end else if (hv[4]) begin
                  fail = 1'b1;
               end else begin
                  nibble_in = hv[3:0];
                  fdb_in    = 1'b0;
                  phase_in  = pcd_pkg::PH_DIG1;
               end
            end
            pcd_pkg::PH_DIG1: begin
               if (fdb_ff) begin
                  if (req.in_byte == pcd_pkg::CH_TWO && !req.in_last) begin
                     phase_in = pcd_pkg::PH_PCT2;
                  end else begin
                     fail = 1'b1;
                  end
               end else if (hv[4]) begin
                  fail = 1'b1;
               end else begin
                  q_push     = 1'b1;
                  q_cmd.data = {nibble_ff, hv[3:0]};
                  phase_in   = pcd_pkg::PH_IDLE;
               end
            end
            pcd_pkg::PH_PCT2: begin
               if (req.in_byte != pcd_pkg::CH_FIVE) begin
                  fail = 1'b1;
               end else begin
                  q_push       = 1'b1;
                  q_cmd.data   = pcd_pkg::CH_PERCENT;
                  q_cmd.triple = 1'b1;
                  phase_in     = pcd_pkg::PH_IDLE;
                  fdb_in       = 1'b0;
               end
            end
            pcd_pkg::PH_DROP: begin
               if (req.in_last) begin
                  phase_in = pcd_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = pcd_pkg::PH_IDLE;
            end
         endcase
         if (fail) begin
            q_push       = 1'b1;
            q_cmd.data   = 8'd0;
            q_cmd.last   = 1'b1;
            q_cmd.status = fail_status;
            phase_in     = req.in_last ? pcd_pkg::PH_IDLE : pcd_pkg::PH_DROP;
            fdb_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pcd_pkg::PH_IDLE;
         nibble_ff <= 4'd0;
         fdb_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         nibble_ff <= nibble_in;
         fdb_ff    <= fdb_in;
      end
   end

endmodule

FILE: hw/rtl/pcd_cmd_queue.sv
`include "percent_decoder_macros.svh"

// Small FIFO of commands between the parser and the output side.
module pcd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output pcd_pkg::cmd_type pop_cmd,
   output logic             empty
);

   pcd_pkg::cmd_type                entry_ff [pcd_pkg::QDEPTH];
   logic [pcd_pkg::QIDX_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pcd_pkg::QIDX_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pcd_pkg::QCNT_W-1:0]      count_ff, count_in;

   localparam logic [pcd_pkg::QIDX_W-1:0] LAST_IDX = pcd_pkg::QIDX_W'(pcd_pkg::QDEPTH - 1);

   assign full    = (count_ff == pcd_pkg::QCNT_W'(pcd_pkg::QDEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PCD_ASSERT_IMP(a_no_overflow, clock, reset, push, !full)
   `PCD_ASSERT_IMP(a_no_underflow, clock, reset, pop, !empty)
   `PCD_ASSERT(a_count_range, clock, reset, count_ff <= pcd_pkg::QCNT_W'(pcd_pkg::QDEPTH))

endmodule

FILE: hw/rtl/pcd_back.sv
`include "percent_decoder_macros.svh"

// Output side: turns commands into result transactions through a
// registered output stage. A triple command gives three results.
module pcd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  pcd_pkg::cmd_type q_cmd,
   output logic             q_pop,
   pcd_rsp_if.source        rsp
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] status_ff, status_in;
   logic [1:0] rem_ff, rem_in;
   logic       tail_last_ff, tail_last_in;
   logic       advance;

   assign advance = !valid_ff || rsp.ready;
   assign q_pop   = advance && (rem_ff == 2'd0) && !q_empty;

   always_comb begin
      valid_in     = valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      rem_in       = rem_ff;
      tail_last_in = tail_last_ff;
      if (advance) begin
         if (rem_ff != 2'd0) begin
            valid_in  = 1'b1;
            byte_in   = (rem_ff == 2'd2) ? pcd_pkg::CH_TWO : pcd_pkg::CH_FIVE;
            last_in   = (rem_ff == 2'd1) ? tail_last_ff : 1'b0;
            status_in = pcd_pkg::STATUS_OK;
            rem_in    = rem_ff - 2'd1;
         end else if (!q_empty) begin
            valid_in  = 1'b1;
            byte_in   = q_cmd.data;
            status_in = q_cmd.status;
            if (q_cmd.triple) begin
               last_in      = 1'b0;
               rem_in       = 2'd2;
               tail_last_in = q_cmd.last;
            end else begin
               last_in = q_cmd.last;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rem_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
      tail_last_ff <= tail_last_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.out_last = last_ff;
   assign rsp.status   = status_ff;

   `PCD_ASSERT_IMP(a_tail_pending_valid, clock, reset, rem_ff != 2'd0, valid_ff)
   `PCD_ASSERT_IMP(a_tail_not_last, clock, reset, rem_ff != 2'd0, !last_ff)

endmodule

FILE: hw/rtl/percent_decoder.sv
// Streaming URL percent decoder. Raw characters arrive on req_bus, one
// transaction per character with in_last on the final character of a
// string; decoded characters leave on rsp_bus with out_last on the final
// result of the string and a status of ok, bad hex digit or truncated
// escape. The block takes one transaction per cycle. Most characters give
// zero or one result, so results leave at the input rate; the literal
// "%%25" gives three results, which the output stage sends in order,
// uninterrupted. A four-entry command queue between the parser and
// the output stage absorbs these bursts and any stall on rsp_bus, and
// req_bus.ready drops only while that queue is full. An error ends the
// string with one error result (out_byte zero, out_last set) and the
// remaining characters up to in_last are consumed silently. The
// plus_to_space setting is written through csr_we/csr_wdata and turns
// '+' outside an escape into a space; write it only while the block is idle.
module percent_decoder (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_we,
   input  logic      csr_wdata,
   pcd_req_if.sink   req_bus,
   pcd_rsp_if.source rsp_bus
);

   // The single configuration bit.
   logic plus_to_space_ff, plus_to_space_in;

   // Command path between the parser and the output stage.
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   pcd_pkg::cmd_type push_cmd;
   pcd_pkg::cmd_type pop_cmd;

   assign plus_to_space_in = csr_we ? csr_wdata : plus_to_space_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_to_space_ff <= 1'b0;
      end else begin
         plus_to_space_ff <= plus_to_space_in;
      end
   end

   // Front end: escape parsing, one transaction per cycle while the queue has room.
   pcd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .plus_to_space (plus_to_space_ff),
      .req           (req_bus),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   // Decouples the parser from output stalls.
   pcd_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   // Back end: expands commands into result transactions.
   pcd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule

FILE: test/tb_percent_decoder.sv
module tb_percent_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   // Clock and run sizing.
   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 2;
   localparam int RANDOM_ITEMS  = 400;
   localparam int RANDOM_PHASES = 6;
   // The output side holds at most a four-entry command queue plus what the
   // output stage holds, so this idle wait is more than enough to let a
   // result-less character finish its trip through the parser.
   localparam int SETTLE_CYCLES = 12;
   // One long stall of the result side, long enough to fill the queue and
   // push back on the character channel.
   localparam int HOLD_CYCLES   = 80;
   // The slowest correct run is roughly 470 transactions, each with a random
   // idle gap on the sender and up to three results that each wait out a
   // random stall, plus the long hold. Allow far more.
   localparam int CYCLE_LIMIT   = 200000;

   // One decoded character as seen on the result channel.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
   } decoded_type;

   // A raw encoded string, one byte per entry.
   typedef logic [7:0] text_type[$];

   // Tracks the decoder's escape parser and holds the decoded characters
   // that are still owed by the block, oldest first.
   class decode_checker;
      decoded_type         expected_chars[$];
      logic                plus_to_space = 1'b0;
      pcd_pkg::phase_type  phase         = pcd_pkg::PH_IDLE;
      logic [3:0]          high_digit    = 4'd0;
      logic                pct_first     = 1'b0;
      int                  mismatches    = 0;

      // Hex digit value 0..15, or 16 when the byte is not a hex digit.
      // Letters are folded to lower case after digits are handled, since
      // folding would otherwise pull control codes into the digit range.
      static function logic [4:0] digit_of(input logic [7:0] c);
         logic [7:0] folded;
         folded = c | (pcd_pkg::CH_LOWER_A ^ pcd_pkg::CH_UPPER_A);
         if (c >= pcd_pkg::CH_ZERO && c <= pcd_pkg::CH_NINE) begin
            return {1'b0, c[3:0]};
         end
         if (folded >= pcd_pkg::CH_LOWER_A && folded <= pcd_pkg::CH_LOWER_F) begin
            return 5'(folded - pcd_pkg::CH_LOWER_A + pcd_pkg::HEX_ALPHA_BASE);
         end
         return 5'd16;
      endfunction

      function void owe(input logic [7:0] d, input logic l, input logic [1:0] st);
         decoded_type item;
         item.data   = d;
         item.last   = l;
         item.status = st;
         expected_chars = {expected_chars, item};
      endfunction

      // An error closes the string with a single zero byte. The rest of the
      // string is swallowed unless the failing byte was already its last.
      function void owe_error(input logic [1:0] st, input logic l);
         owe(8'd0, 1'b1, st);
         phase     = l ? pcd_pkg::PH_IDLE : pcd_pkg::PH_DROP;
         pct_first = 1'b0;
      endfunction

      // Advances the parser by one accepted character transaction.
      function void note_char(input logic [7:0] c, input logic l);
         logic [4:0] v;
         v = digit_of(c);
         case (phase)
            pcd_pkg::PH_DROP: begin
               if (l) phase = pcd_pkg::PH_IDLE;
            end
            pcd_pkg::PH_PCT: begin
               if (l) begin
                  owe_error(pcd_pkg::STATUS_TRUNC, l);
               end else if (c == pcd_pkg::CH_PERCENT) begin
                  pct_first  = 1'b1;
                  high_digit = 4'd0;
                  phase      = pcd_pkg::PH_DIG1;
               end else if (v[4]) begin
                  owe_error(pcd_pkg::STATUS_BAD_HEX, l);
               end else begin
                  high_digit = v[3:0];
                  pct_first  = 1'b0;
                  phase      = pcd_pkg::PH_DIG1;
               end
            end
            pcd_pkg::PH_DIG1: begin
               if (pct_first) begin
                  if (c == pcd_pkg::CH_TWO && !l) phase = pcd_pkg::PH_PCT2;
                  else owe_error(pcd_pkg::STATUS_BAD_HEX, l);
               end else if (v[4]) begin
                  owe_error(pcd_pkg::STATUS_BAD_HEX, l);
               end else begin
                  owe({high_digit, v[3:0]}, l, pcd_pkg::STATUS_OK);
                  phase = pcd_pkg::PH_IDLE;
               end
            end
            pcd_pkg::PH_PCT2: begin
               if (c != pcd_pkg::CH_FIVE) begin
                  owe_error(pcd_pkg::STATUS_BAD_HEX, l);
               end else begin
                  owe(pcd_pkg::CH_PERCENT, 1'b0, pcd_pkg::STATUS_OK);
                  owe(pcd_pkg::CH_TWO, 1'b0, pcd_pkg::STATUS_OK);
                  owe(pcd_pkg::CH_FIVE, l, pcd_pkg::STATUS_OK);
                  phase     = pcd_pkg::PH_IDLE;
                  pct_first = 1'b0;
               end
            end
            default: begin
               phase = pcd_pkg::PH_IDLE;
               if (c == pcd_pkg::CH_PERCENT) begin
                  if (l) owe_error(pcd_pkg::STATUS_TRUNC, l);
                  else phase = pcd_pkg::PH_PCT;
               end else if (plus_to_space && c == pcd_pkg::CH_PLUS) begin
                  owe(pcd_pkg::CH_SPACE, l, pcd_pkg::STATUS_OK);
               end else begin
                  owe(c, l, pcd_pkg::STATUS_OK);
               end
            end
         endcase
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("%0t: mismatch: %s", $realtime, what);
      endtask

      // Compares one accepted result transaction with the oldest owed one.
      task check_decoded(input decoded_type got);
         decoded_type want;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h last %0b status %0d",
                                      got.data, got.last, got.status));
            return;
         end
         want = expected_chars.pop_front();
         if (got.data !== want.data)
            report_mismatch($sformatf("out_byte %02h, wanted %02h", got.data, want.data));
         if (got.last !== want.last)
            report_mismatch($sformatf("out_last %0b, wanted %0b", got.last, want.last));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      endtask
   endclass

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic csr_we;
   logic csr_wdata;

   pcd_req_if req_bus ();
   pcd_rsp_if rsp_bus ();

   decode_checker tracker = new;

   // Shared knobs between the stimulus and the result-side process. When
   // steady_flow is set neither side idles; hold_request asks the result
   // side for one long stall.
   bit steady_flow  = 1'b0;
   bit hold_request = 1'b0;
   int items_sent   = 0;
   int cycle_count  = 0;

   percent_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Random hex digit character, upper or lower case at random.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] letter_base;
      letter_base = $urandom_range(0, 1) ? pcd_pkg::CH_UPPER_A : pcd_pkg::CH_LOWER_A;
      if (v < pcd_pkg::HEX_ALPHA_BASE) return pcd_pkg::CH_ZERO + 8'(v);
      return letter_base + 8'(v) - 8'(pcd_pkg::HEX_ALPHA_BASE);
   endfunction

   // Random byte that is not a hex digit. A percent sign is left out where
   // it would open the literal "%%25" path instead of failing.
   function automatic logic [7:0] non_hex_char(input bit allow_percent);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (decode_checker::digit_of(b) < 16 ||
                 (!allow_percent && b == pcd_pkg::CH_PERCENT));
      return b;
   endfunction

   // Offers one character transaction after a random gap and waits until
   // the block takes it. Valid stays high on return so that back-to-back
   // transactions need no idle gap; the prediction is made at the edge
   // at which the transaction is accepted.
   task automatic send_char(input logic [7:0] c, input logic l);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid   <= 1'b0;
         req_bus.in_byte <= 8'($urandom);
         req_bus.in_last <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= c;
      req_bus.in_last <= l;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_char(c, l);
      items_sent++;
   endtask

   task automatic send_text(input text_type s);
      foreach (s[i]) send_char(s[i], i == s.size() - 1);
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Builds one string from a mix of pieces and sends it. Most pieces are
   // well-formed (plain bytes, plus signs, escapes, the literal "%%25") so
   // that the parser gets deep into its escape phases; the rest are
   // malformed escapes, escapes cut by the end of the string, and raw noise.
   task automatic send_random_text();
      text_type   s;
      int         pieces;
      int         kind;
      logic [7:0] b;
      pieces = $urandom_range(1, 6);
      for (int k = 0; k < pieces; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            b = 8'($urandom_range(0, 255));
            s = {s, ((b == pcd_pkg::CH_PERCENT) ? pcd_pkg::CH_PLUS : b)};
         end else if (kind < 40) begin
            s = {s, pcd_pkg::CH_PLUS};
         end else if (kind < 62) begin
            s = {s, pcd_pkg::CH_PERCENT};
            s = {s, hex_char(4'($urandom))};
            s = {s, hex_char(4'($urandom))};
         end else if (kind < 70) begin
            s = {s, pcd_pkg::CH_PERCENT};
            s = {s, pcd_pkg::CH_PERCENT};
            s = {s, pcd_pkg::CH_TWO};
            s = {s, pcd_pkg::CH_FIVE};
         end else if (kind < 80) begin
            // Malformed escape: the bytes after it are swallowed by the block.
            s = {s, pcd_pkg::CH_PERCENT};
            case ($urandom_range(0, 3))
               0: s = {s, non_hex_char(1'b0)};
               1: begin
                  s = {s, hex_char(4'($urandom))};
                  s = {s, non_hex_char(1'b1)};
               end
               2: begin
                  s = {s, pcd_pkg::CH_PERCENT};
                  b = 8'($urandom_range(0, 255));
                  s = {s, ((b == pcd_pkg::CH_TWO) ? pcd_pkg::CH_FIVE : b)};
               end
               default: begin
                  s = {s, pcd_pkg::CH_PERCENT};
                  s = {s, pcd_pkg::CH_TWO};
                  b = 8'($urandom_range(0, 255));
                  s = {s, ((b == pcd_pkg::CH_FIVE) ? pcd_pkg::CH_TWO : b)};
               end
            endcase
         end else if (kind < 86) begin
            // Escape cut short by the end of the string.
            s = {s, pcd_pkg::CH_PERCENT};
            if ($urandom_range(0, 1)) s = {s, 8'($urandom_range(0, 255))};
            break;
         end else begin
            s = {s, 8'($urandom_range(0, 255))};
         end
      end
      send_text(s);
   endtask

   // Pauses the sender until every owed result has arrived, then lets the
   // block settle so that the register can be written safely.
   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      while (tracker.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the plus-to-space register; only called while the block is idle.
   task automatic write_plus_to_space(input logic v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.plus_to_space = v;
   endtask

   // Result side: draws a stall before each result transaction, serves the
   // one long hold when asked, and checks every accepted result in order.
   initial begin
      int          stall;
      decoded_type got;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 4);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            stall        = 0;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.data   = rsp_bus.out_byte;
         got.last   = rsp_bus.out_last;
         got.status = rsp_bus.status;
         tracker.check_decoded(got);
      end
   end

   // Stimulus: reset, a short directed pass over the special cases, then
   // random strings in several phases with the register flipped between
   // phases, one phase without idling and one with the long result stall.
   initial begin
      int target;
      csr_we          <= 1'b0;
      csr_wdata       <= 1'b0;
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= 8'd0;
      req_bus.in_last <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_plus_to_space(1'b0);

      // Byte extremes, a plus sign kept as is, escapes in both cases, the
      // largest escaped value and the literal "%%25" closing the string.
      send_char(8'h00, 1'b0);
      send_str("+%4a%FF%%25");
      // Escapes cut by the end of the string: a lone percent sign, and a
      // percent sign with one digit.
      send_str("%");
      send_str("%4");
      // A plus sign is not a hex digit; the trailing byte is swallowed.
      send_str("%+1");
      // "%%2" followed by the wrong byte, which is also the last byte, so
      // decoding starts over at once.
      send_str("%%24");
      wait_for_quiet();

      // With the conversion on: a full-scale byte, a plus turned into a
      // space, then a bad second digit on the last byte.
      write_plus_to_space(1'b1);
      send_char(8'hFF, 1'b0);
      send_str("+%az");
      wait_for_quiet();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_plus_to_space(p % 2 == 0 ? 1'b0 : 1'b1);
         steady_flow = (p == 2);
         if (p == 4) hold_request = 1'b1;
         target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < target) send_random_text();
         wait_for_quiet();
         steady_flow = 1'b0;
      end

      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_if.sv
hw/rtl/pcd_front.sv
hw/rtl/pcd_cmd_queue.sv
hw/rtl/pcd_back.sv
hw/rtl/percent_decoder.sv
test/tb_percent_decoder.sv
